// File: hdl/sms_pkg.sv
// Package with the shared types and constants of the sorted matrix search core.
`default_nettype none

package sms_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int VALUE_W     = 32;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int CNT_W       = 5;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int STACK_DEPTH = 16;
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int STK_PTR_W   = STK_IDX_W + 1;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic             op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_value           value;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] found_row;
        logic [COL_W-1:0] found_col;
    } t_rsp;

    // Half-open region: columns left..right-1, rows top..bottom-1.
    typedef struct packed {
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] right;
        logic [CNT_W-1:0] top;
        logic [CNT_W-1:0] bottom;
    } t_region;

    typedef struct packed {
        logic [CNT_W-1:0] rows_in_use;
        logic [CNT_W-1:0] cols_in_use;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic push_pair;
        logic pop;
    } t_stk_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CMP
    } t_state;

endpackage

`default_nettype wire

// File: hdl/sorted_matrix_search_core.sv
// Top level of the sorted matrix search core: sequencer and datapath.
//
//  Channel   Ports                              Handshake
//  --------  ---------------------------------  ------------------------------
//  request   start, busy, i_req                 taken when start & !busy
//  result    o_valid, o_rsp                     one-cycle strobe, no stall
//  config    psel penable pwrite paddr pwdata   APB-style, pready always high
//            prdata pready
//
// A write request stores one entry and gives no result.
// A search runs a depth-first walk over quadrant regions. Each non-empty
// region uses the single memory read port in the states EVAL (issue the
// read) and CMP (compare), and each empty region passes through EVAL
// alone, so the time depends on the data. The result strobe comes in
// the cycle the core returns to idle, and busy is low in that same cycle.
// Reset is synchronous and active low; the matrix memory is not cleared.
// The receiver cannot stall the result.
`default_nettype none

module sorted_matrix_search_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  sms_pkg::t_req                    i_req,
    output logic                             o_valid,
    output sms_pkg::t_rsp                    o_rsp,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [sms_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire [sms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    sms_pkg::t_state    r_state;
    sms_pkg::t_state    n_state;
    sms_pkg::t_region   r_cur;
    sms_pkg::t_region   n_cur;
    sms_pkg::t_value    r_key;
    logic               r_single;
    logic               n_single;
    logic               r_valid;
    logic               n_valid;
    sms_pkg::t_rsp      r_rsp;
    sms_pkg::t_rsp      n_rsp;

    sms_pkg::t_cfg      w_cfg;
    sms_pkg::t_stk_ctl  w_stk;
    sms_pkg::t_region   w_top;
    logic               w_stk_empty;
    sms_pkg::t_value    w_rdata;
    logic [sms_pkg::ADDR_W-1:0] w_raddr;
    logic               w_accept;
    logic               w_mem_we;

    logic               w_empty;
    logic               w_one;
    logic               w_hit;
    logic               w_ge;
    logic [sms_pkg::CNT_W:0]   w_rsum;
    logic [sms_pkg::CNT_W:0]   w_csum;
    logic [sms_pkg::CNT_W-1:0] w_mr;
    logic [sms_pkg::CNT_W-1:0] w_mc;
    sms_pkg::t_region   w_tr;
    sms_pkg::t_region   w_bl;
    sms_pkg::t_region   w_third;

    sms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_accept = start & (r_state == sms_pkg::ST_IDLE);
    assign w_mem_we = w_accept & (i_req.op == sms_pkg::OP_WRITE);

    sms_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr ({i_req.row, i_req.col}),
        .i_wdata (i_req.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sms_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_stk),
        .i_deep  (w_third),
        .i_near  (w_bl),
        .o_top   (w_top),
        .o_empty (w_stk_empty)
    );

    // Geometry of the current region: emptiness, single entry, midpoints.
    assign w_empty = (r_cur.left >= r_cur.right) || (r_cur.top >= r_cur.bottom);
    assign w_one   = (r_cur.left + sms_pkg::CNT_W'(1) == r_cur.right) &&
                     (r_cur.top + sms_pkg::CNT_W'(1) == r_cur.bottom);
    assign w_rsum  = {1'b0, r_cur.top} + {1'b0, r_cur.bottom};
    assign w_csum  = {1'b0, r_cur.left} + {1'b0, r_cur.right};
    assign w_mr    = w_rsum[sms_pkg::CNT_W:1];
    assign w_mc    = w_csum[sms_pkg::CNT_W:1];

    // A single entry reads itself; a larger region reads its center entry.
    assign w_raddr = w_one ?
        {r_cur.top[sms_pkg::ROW_W-1:0], r_cur.left[sms_pkg::COL_W-1:0]} :
        {w_mr[sms_pkg::ROW_W-1:0], w_mc[sms_pkg::COL_W-1:0]};

    // The comparison unit shared by every step of the walk.
    assign w_hit = (w_rdata == r_key);
    assign w_ge  = (r_key >= w_rdata);

    // Sub-regions. The top-right block is tried first, then bottom-left,
    // then bottom-right when the target is at least the center entry,
    // otherwise top-left.
    assign w_tr = '{left: w_mc, right: r_cur.right, top: r_cur.top, bottom: w_mr};
    assign w_bl = '{left: r_cur.left, right: w_mc, top: w_mr, bottom: r_cur.bottom};
    assign w_third = w_ge ?
        '{left: w_mc, right: r_cur.right, top: w_mr, bottom: r_cur.bottom} :
        '{left: r_cur.left, right: w_mc, top: r_cur.top, bottom: w_mr};

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sms_pkg::ST_IDLE: begin
                if (w_accept && (i_req.op == sms_pkg::OP_SEARCH)) begin
                    n_state = sms_pkg::ST_EVAL;
                end
            end
            sms_pkg::ST_EVAL: begin
                if (w_empty) begin
                    if (w_stk_empty) begin
                        n_state = sms_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = sms_pkg::ST_CMP;
                end
            end
            sms_pkg::ST_CMP: begin
                if (r_single) begin
                    if (w_hit || w_stk_empty) begin
                        n_state = sms_pkg::ST_IDLE;
                    end else begin
                        n_state = sms_pkg::ST_EVAL;
                    end
                end else begin
                    n_state = sms_pkg::ST_EVAL;
                end
            end
            default: n_state = sms_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and result of the sequencer. A match ends the walk
    // at once, so the regions still pending on the stack are discarded.
    always_comb begin
        n_cur    = r_cur;
        n_single = r_single;
        n_valid  = 1'b0;
        n_rsp    = '0;
        w_stk    = '0;
        case (r_state)
            sms_pkg::ST_IDLE: begin
                if (w_accept && (i_req.op == sms_pkg::OP_SEARCH)) begin
                    n_cur = '{left: '0, right: w_cfg.cols_in_use,
                              top: '0, bottom: w_cfg.rows_in_use};
                end
            end
            sms_pkg::ST_EVAL: begin
                n_single = w_one;
                if (w_empty) begin
                    if (w_stk_empty) begin
                        n_valid = 1'b1;
                    end else begin
                        n_cur     = w_top;
                        w_stk.pop = 1'b1;
                    end
                end
            end
            sms_pkg::ST_CMP: begin
                if (r_single) begin
                    if (w_hit) begin
                        n_valid         = 1'b1;
                        n_rsp.found     = 1'b1;
                        n_rsp.found_row = r_cur.top[sms_pkg::ROW_W-1:0];
                        n_rsp.found_col = r_cur.left[sms_pkg::COL_W-1:0];
                        w_stk.clear     = 1'b1;
                    end else if (w_stk_empty) begin
                        n_valid = 1'b1;
                    end else begin
                        n_cur     = w_top;
                        w_stk.pop = 1'b1;
                    end
                end else begin
                    n_cur           = w_tr;
                    w_stk.push_pair = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sms_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_single <= n_single;
        r_rsp    <= n_rsp;
        if (w_accept) begin
            r_key <= i_req.value;
        end
    end

    assign busy    = (r_state != sms_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// File: hdl/sms_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module sms_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [sms_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire [sms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output sms_pkg::t_cfg                    o_cfg
);

    sms_pkg::t_cfg              r_cfg;
    logic [sms_pkg::CNT_W-1:0]  w_val;
    logic [sms_pkg::CNT_W-1:0]  w_rows;
    logic [sms_pkg::CNT_W-1:0]  w_cols;
    logic                       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_val  = pwdata[sms_pkg::CNT_W-1:0];

    // Values beyond the matrix size saturate to it.
    assign w_rows = (w_val > sms_pkg::CNT_W'(sms_pkg::MAX_ROWS)) ?
                    sms_pkg::CNT_W'(sms_pkg::MAX_ROWS) : w_val;
    assign w_cols = (w_val > sms_pkg::CNT_W'(sms_pkg::MAX_COLS)) ?
                    sms_pkg::CNT_W'(sms_pkg::MAX_COLS) : w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_in_use <= sms_pkg::CNT_W'(sms_pkg::MAX_ROWS);
            r_cfg.cols_in_use <= sms_pkg::CNT_W'(sms_pkg::MAX_COLS);
        end else if (w_wr) begin
            case (paddr[2])
                sms_pkg::REG_ROWS_IN_USE: r_cfg.rows_in_use <= w_rows;
                sms_pkg::REG_COLS_IN_USE: r_cfg.cols_in_use <= w_cols;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            sms_pkg::REG_ROWS_IN_USE:
                prdata = sms_pkg::APB_DATA_W'(r_cfg.rows_in_use);
            sms_pkg::REG_COLS_IN_USE:
                prdata = sms_pkg::APB_DATA_W'(r_cfg.cols_in_use);
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hdl/sms_mem.sv
// Matrix entry memory with one write port and one registered read port.
`default_nettype none

module sms_mem (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire [sms_pkg::ADDR_W-1:0]       i_waddr,
    input  sms_pkg::t_value                 i_wdata,
    input  wire [sms_pkg::ADDR_W-1:0]       i_raddr,
    output sms_pkg::t_value                 o_rdata
);

    sms_pkg::t_value r_mem [sms_pkg::MAX_ROWS*sms_pkg::MAX_COLS];
    sms_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/sms_stack.sv
// Stack of pending search regions; pushes two regions or pops one per cycle.
`default_nettype none

module sms_stack (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sms_pkg::t_stk_ctl   i_ctl,
    input  sms_pkg::t_region    i_deep,
    input  sms_pkg::t_region    i_near,
    output sms_pkg::t_region    o_top,
    output logic                o_empty
);

    sms_pkg::t_region               r_mem [sms_pkg::STACK_DEPTH];
    logic [sms_pkg::STK_PTR_W-1:0]  r_ptr;
    logic [sms_pkg::STK_PTR_W-1:0]  w_ptr_p1;
    logic [sms_pkg::STK_PTR_W-1:0]  w_ptr_m1;

    assign w_ptr_p1 = r_ptr + sms_pkg::STK_PTR_W'(1);
    assign w_ptr_m1 = r_ptr - sms_pkg::STK_PTR_W'(1);

    // A search that ends on a match drops whatever regions are still pending.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_ctl.clear) begin
            r_ptr <= '0;
        end else if (i_ctl.push_pair) begin
            r_ptr <= r_ptr + sms_pkg::STK_PTR_W'(2);
        end else if (i_ctl.pop) begin
            r_ptr <= w_ptr_m1;
        end
    end

    // The region to be tried later goes deeper than the one tried sooner.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_pair) begin
            r_mem[r_ptr[sms_pkg::STK_IDX_W-1:0]]    <= i_deep;
            r_mem[w_ptr_p1[sms_pkg::STK_IDX_W-1:0]] <= i_near;
        end
    end

    assign o_top   = r_mem[w_ptr_m1[sms_pkg::STK_IDX_W-1:0]];
    assign o_empty = (r_ptr == '0);

endmodule

`default_nettype wire

// File: dv/tb_sorted_matrix_search_core.sv
// Self-checking testbench for the sorted matrix search core.
`timescale 1ns / 100ps

module tb_sorted_matrix_search_core;

    // Register addresses: one 32-bit register per word.
    localparam logic [sms_pkg::APB_ADDR_W-1:0] ADDR_ROWS = {sms_pkg::REG_ROWS_IN_USE, 2'b00};
    localparam logic [sms_pkg::APB_ADDR_W-1:0] ADDR_COLS = {sms_pkg::REG_COLS_IN_USE, 2'b00};

    localparam sms_pkg::t_value VAL_MIN = {1'b1, {(sms_pkg::VALUE_W-1){1'b0}}};
    localparam sms_pkg::t_value VAL_MAX = {1'b0, {(sms_pkg::VALUE_W-1){1'b1}}};

    // Requests over the whole run, directed part included.
    localparam int TOTAL_ITEMS = 2000;
    // Quiet period after the drain, to catch any stray strobe.
    localparam int SETTLE_CYCLES = 600;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    sms_pkg::t_req                  i_req;
    logic                           o_valid;
    sms_pkg::t_rsp                  o_rsp;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [sms_pkg::APB_ADDR_W-1:0] paddr;
    logic [sms_pkg::APB_DATA_W-1:0] pwdata;
    logic [sms_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    sorted_matrix_search_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block: matrix contents and the active region.
    // ------------------------------------------------------------------
    sms_pkg::t_value grid [sms_pkg::MAX_ROWS][sms_pkg::MAX_COLS];
    int     cfg_rows;
    int     cfg_cols;

    // Answers still owed by the block, oldest first.
    sms_pkg::t_rsp answers_due [$];

    int     errors;
    int     n_writes;
    int     n_searches;
    int     n_hits;
    int     n_reg_writes;
    int     n_items;
    int     idle_pct;

    // Quadrant walk over the half-open region cols l..r-1, rows t..b-1.
    // Top-right first, then bottom-left, then bottom-right when the target
    // is at least the center entry, otherwise top-left.
    function automatic bit probe_block(input sms_pkg::t_value key, input int l,
                                       input int r, input int t, input int b,
                                       output int fr, output int fc);
        int mr;
        int mc;
        fr = 0;
        fc = 0;
        if (l + 1 == r && t + 1 == b) begin
            if (grid[t][l] == key) begin
                fr = t;
                fc = l;
                return 1'b1;
            end
            return 1'b0;
        end
        if (l >= r || t >= b)
            return 1'b0;
        mr = (t + b) / 2;
        mc = (l + r) / 2;
        if (probe_block(key, mc, r, t, mr, fr, fc))
            return 1'b1;
        if (probe_block(key, l, mc, mr, b, fr, fc))
            return 1'b1;
        if (key >= grid[mr][mc])
            return probe_block(key, mc, r, mr, b, fr, fc);
        return probe_block(key, l, mc, t, mr, fr, fc);
    endfunction

    function automatic sms_pkg::t_rsp locate_target(input sms_pkg::t_value key);
        sms_pkg::t_rsp rsp;
        int   fr;
        int   fc;
        bit   hit;
        hit = probe_block(key, 0, cfg_cols, 0, cfg_rows, fr, fc);
        rsp.found     = hit;
        rsp.found_row = hit ? sms_pkg::ROW_W'(fr) : '0;
        rsp.found_col = hit ? sms_pkg::COL_W'(fc) : '0;
        return rsp;
    endfunction

    // Registers keep five bits and saturate at the matrix size.
    function automatic int clamp_size(input logic [sms_pkg::APB_DATA_W-1:0] data,
                                      input int limit);
        int v;
        v = int'(data[sms_pkg::CNT_W-1:0]);
        return (v > limit) ? limit : v;
    endfunction

    // Sorted backdrop loaded before the directed part: strictly ascending
    // along rows and columns, all values distinct.
    function automatic sms_pkg::t_value fill_value(input int r, input int c);
        return sms_pkg::t_value'(r * 1000 + c * 10 - 100000);
    endfunction

    // ------------------------------------------------------------------
    // Result checker. The strobe lasts one cycle and cannot be held off,
    // so every strobe is compared against the oldest owed answer.
    // ------------------------------------------------------------------
    sms_pkg::t_rsp owed;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                $error("result with no request outstanding: found=%0d row=%0d col=%0d",
                       o_rsp.found, o_rsp.found_row, o_rsp.found_col);
                errors++;
            end else begin
                owed = answers_due.pop_front();
                if (o_rsp.found !== owed.found) begin
                    $error("found: expected %0d, got %0d", owed.found, o_rsp.found);
                    errors++;
                end
                if (o_rsp.found_row !== owed.found_row) begin
                    $error("found_row: expected %0d, got %0d", owed.found_row,
                           o_rsp.found_row);
                    errors++;
                end
                if (o_rsp.found_col !== owed.found_col) begin
                    $error("found_col: expected %0d, got %0d", owed.found_col,
                           o_rsp.found_col);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver. Every task is entered and left just after a falling
    // edge; inputs move there, and busy is sampled at the rising edge.
    // ------------------------------------------------------------------
    task automatic issue(input sms_pkg::t_req rq, input bit typed,
                         input sms_pkg::t_rsp want);
        sms_pkg::t_rsp predicted;
        // Sender gaps: each cycle is idle with the current phase's odds.
        while ($urandom_range(99) < idle_pct)
            @(negedge i_clk);
        start = 1'b1;
        i_req = rq;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        // The request was taken at this edge.
        n_items++;
        if (rq.op == sms_pkg::OP_WRITE) begin
            grid[rq.row][rq.col] = rq.value;
            n_writes++;
        end else begin
            predicted = locate_target(rq.value);
            answers_due = {answers_due, (typed ? want : predicted)};
            n_searches++;
            if (predicted.found)
                n_hits++;
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic write_entry(input int r, input int c, input sms_pkg::t_value v);
        sms_pkg::t_req rq;
        rq.op    = sms_pkg::OP_WRITE;
        rq.row   = sms_pkg::ROW_W'(r);
        rq.col   = sms_pkg::COL_W'(c);
        rq.value = v;
        issue(rq, 1'b0, '0);
    endtask

    // A search ignores row and col; they get random bits anyway.
    task automatic search_for(input sms_pkg::t_value v);
        sms_pkg::t_req rq;
        rq.op    = sms_pkg::OP_SEARCH;
        rq.row   = sms_pkg::ROW_W'($urandom);
        rq.col   = sms_pkg::COL_W'($urandom);
        rq.value = v;
        issue(rq, 1'b0, '0);
    endtask

    // Register writes only happen with the core idle: all answers in, busy
    // low, and no write request still landing.
    task automatic write_reg(input logic [sms_pkg::APB_ADDR_W-1:0] addr,
                             input logic [sms_pkg::APB_DATA_W-1:0] data);
        while (answers_due.size() != 0 || busy)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (addr == ADDR_ROWS)
            cfg_rows = clamp_size(data, sms_pkg::MAX_ROWS);
        else if (addr == ADDR_COLS)
            cfg_cols = clamp_size(data, sms_pkg::MAX_COLS);
        n_reg_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed plan: one row per request or register write. A typed row
    // carries its answer; all other searches are checked against the shadow.
    // ------------------------------------------------------------------
    typedef struct {
        bit                             is_reg;
        sms_pkg::t_req                  rq;
        logic [sms_pkg::APB_ADDR_W-1:0] addr;
        logic [sms_pkg::APB_DATA_W-1:0] data;
        bit                             typed;
        sms_pkg::t_rsp                  want;
    } t_step;

    t_step plan [$];

    task automatic add_row(input t_step s);
        plan = {plan, s};
    endtask

    function automatic t_step req_step(input logic op, input int r, input int c,
                                       input sms_pkg::t_value v);
        t_step s;
        s.is_reg   = 1'b0;
        s.rq.op    = op;
        s.rq.row   = sms_pkg::ROW_W'(r);
        s.rq.col   = sms_pkg::COL_W'(c);
        s.rq.value = v;
        s.addr     = '0;
        s.data     = '0;
        s.typed    = 1'b0;
        s.want     = '0;
        return s;
    endfunction

    function automatic t_step typed_step(input sms_pkg::t_value v, input logic hit,
                                         input int r, input int c);
        t_step s;
        s = req_step(sms_pkg::OP_SEARCH, 0, 0, v);
        s.typed          = 1'b1;
        s.want.found     = hit;
        s.want.found_row = sms_pkg::ROW_W'(r);
        s.want.found_col = sms_pkg::COL_W'(c);
        return s;
    endfunction

    function automatic t_step reg_step(input logic [sms_pkg::APB_ADDR_W-1:0] addr,
                                       input logic [sms_pkg::APB_DATA_W-1:0] data);
        t_step s;
        s = req_step(sms_pkg::OP_WRITE, 0, 0, '0);
        s.is_reg = 1'b1;
        s.addr   = addr;
        s.data   = data;
        return s;
    endfunction

    initial begin
        int     r;
        int     c;
        int     k;
        int     rounds;
        int     n_search;
        int     pick;
        int     rs;
        int     cs;
        bit     scrambled;
        sms_pkg::t_value base;
        sms_pkg::t_value target;
        logic [sms_pkg::APB_DATA_W-1:0] size_w;

        errors       = 0;
        n_writes     = 0;
        n_searches   = 0;
        n_hits       = 0;
        n_reg_writes = 0;
        n_items      = 0;
        idle_pct     = 0;
        rounds       = 0;
        cfg_rows     = sms_pkg::MAX_ROWS;
        cfg_cols     = sms_pkg::MAX_COLS;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // The matrix memory is not cleared by reset, so every entry is
        // written before any search can read it.
        for (r = 0; r < sms_pkg::MAX_ROWS; r++)
            for (c = 0; c < sms_pkg::MAX_COLS; c++)
                write_entry(r, c, fill_value(r, c));

        // Extremes at the corners, searched with the reset region of 16 x 16.
        add_row(req_step(sms_pkg::OP_WRITE, 0, 0, VAL_MIN));
        add_row(req_step(sms_pkg::OP_WRITE, sms_pkg::MAX_ROWS-1, sms_pkg::MAX_COLS-1,
                         VAL_MAX));
        add_row(typed_step(VAL_MIN, 1'b1, 0, 0));
        add_row(typed_step(VAL_MAX, 1'b1, sms_pkg::MAX_ROWS-1, sms_pkg::MAX_COLS-1));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(7, 9)));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(8, 8)));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(0, 15)));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(15, 0)));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, '0));
        // Empty region: nothing can be found.
        add_row(reg_step(ADDR_ROWS, 32'd0));
        add_row(typed_step(fill_value(3, 3), 1'b0, 0, 0));
        // Oversized row count saturates, but zero columns still empties it.
        add_row(reg_step(ADDR_ROWS, 32'd31));
        add_row(reg_step(ADDR_COLS, 32'd0));
        add_row(typed_step(VAL_MIN, 1'b0, 0, 0));
        // Upper data bits are dropped; 17 saturates to the full width.
        add_row(reg_step(ADDR_COLS, 32'hFFFF_FFF1));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(3, 12)));
        // Single row and single column regions.
        add_row(reg_step(ADDR_ROWS, 32'd1));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(0, 3)));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(0, 12)));
        add_row(reg_step(ADDR_ROWS, 32'd16));
        add_row(reg_step(ADDR_COLS, 32'd1));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, fill_value(5, 0)));
        // One-entry region compares the corner directly.
        add_row(reg_step(ADDR_ROWS, 32'd1));
        add_row(typed_step(VAL_MIN, 1'b1, 0, 0));
        // Break the ordering and see which copy of the maximum is reported.
        add_row(reg_step(ADDR_ROWS, 32'd16));
        add_row(reg_step(ADDR_COLS, 32'd16));
        add_row(req_step(sms_pkg::OP_WRITE, 4, 4, VAL_MAX));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, VAL_MAX));
        add_row(req_step(sms_pkg::OP_SEARCH, 0, 0, -1));

        foreach (plan[i]) begin
            if (plan[i].is_reg)
                write_reg(plan[i].addr, plan[i].data);
            else
                issue(plan[i].rq, plan[i].typed, plan[i].want);
        end

        // Random rounds. Each round sets a region, loads it (mostly with a
        // sorted pattern) and then searches it, with a few stray writes.
        // The idling phase rotates: none, heavy, none, light.
        while (n_items < TOTAL_ITEMS) begin
            case (rounds % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 64;
                2:       idle_pct = 0;
                default: idle_pct = 22;
            endcase
            rounds++;

            // Mostly small regions; the full size and odd values now and then.
            for (k = 0; k < 2; k++) begin
                pick = $urandom_range(15);
                if (pick == 0)
                    size_w = sms_pkg::APB_DATA_W'($urandom_range(31));
                else if (pick < 3)
                    size_w = 16;
                else
                    size_w = sms_pkg::APB_DATA_W'($urandom_range(1, 8));
                if ($urandom_range(3) == 0)
                    size_w[sms_pkg::APB_DATA_W-1:sms_pkg::CNT_W] =
                        (sms_pkg::APB_DATA_W-sms_pkg::CNT_W)'($urandom >> sms_pkg::CNT_W);
                write_reg((k == 0) ? ADDR_ROWS : ADDR_COLS, size_w);
            end

            scrambled = ($urandom_range(7) == 0);
            base = sms_pkg::t_value'($urandom) >>> $urandom_range(0, 12);
            rs   = $urandom_range(0, 2000);
            cs   = $urandom_range(0, 100);
            for (r = 0; r < cfg_rows; r++)
                for (c = 0; c < cfg_cols; c++)
                    write_entry(r, c, scrambled ? sms_pkg::t_value'($urandom)
                                                : sms_pkg::t_value'(base + r * rs + c * cs));

            n_search = $urandom_range(6, 30);
            repeat (n_search) begin
                k = $urandom_range(99);
                if (k < 8) begin
                    write_entry($urandom_range(sms_pkg::MAX_ROWS-1),
                                $urandom_range(sms_pkg::MAX_COLS-1),
                                sms_pkg::t_value'($urandom));
                end else begin
                    if (cfg_rows > 0 && cfg_cols > 0 && k < 72) begin
                        target = grid[$urandom_range(cfg_rows-1)][$urandom_range(cfg_cols-1)];
                        // Near misses on either side of a stored value.
                        if (k >= 60)
                            target = $urandom_range(1) ? target + 1 : target - 1;
                    end else if (k < 84) begin
                        case ($urandom_range(3))
                            0:       target = VAL_MIN;
                            1:       target = VAL_MAX;
                            2:       target = '0;
                            default: target = -1;
                        endcase
                    end else begin
                        target = sms_pkg::t_value'($urandom);
                    end
                    search_for(target);
                end
            end
        end

        // Drain: every owed answer must arrive, then nothing more may show up.
        idle_pct = 0;
        for (k = 0; k < 200000 && (answers_due.size() != 0 || busy); k++)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (answers_due.size() != 0) begin
            $error("%0d expected results never arrived", answers_due.size());
            errors++;
        end

        $display("Ran %0d rounds: %0d entry writes, %0d searches (%0d hits), %0d register writes.",
                 rounds, n_writes, n_searches, n_hits, n_reg_writes);
        if (errors == 0)
            $display("tb_sorted_matrix_search_core: PASS");
        else
            $display("tb_sorted_matrix_search_core: FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #60_000_000;
        $display("tb_sorted_matrix_search_core: FAIL");
        $finish;
    end

endmodule
